[design/dq_pkg.sv]
// Shared constants, codes and types of the double-ended queue.
// Used by dq_cell and double_ended_queue; depends on nothing else.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_LIST       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cell control: take the left neighbour, the right neighbour or the pushed value.
    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic load;
    } cell_ctl_t;

endpackage

[design/dq_cell.sv]
// One storage cell of the queue row; it takes a neighbour's or the pushed value.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_cell (
    input  logic                            aclk,
    input  dq_pkg::cell_ctl_t               ctl,
    input  logic signed [dq_pkg::DATA_W-1:0] left_in,
    input  logic signed [dq_pkg::DATA_W-1:0] right_in,
    input  logic signed [dq_pkg::DATA_W-1:0] ext_in,
    output logic signed [dq_pkg::DATA_W-1:0] q
);

    logic signed [dq_pkg::DATA_W-1:0] value_reg;
    logic signed [dq_pkg::DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.load) begin
            value_next = ext_in;
        end else if (ctl.shift_r) begin
            value_next = left_in;
        end else if (ctl.shift_l) begin
            value_next = right_in;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

[design/double_ended_queue.sv]
// Top level of the bounded double-ended queue: control, cell row and result register.
// Depends on dq_pkg and dq_cell.
`timescale 1ns / 1ps

// Usage
// The input channel (s_valid, s_ready, s_action, s_item_value) carries one request
// per handshake: push front, push back, pop front, pop back, clear or list.
// The result channel (m_valid, m_ready, m_result_value, m_status, m_last_of_run)
// returns one result per push, pop or clear, and one result per stored element
// for a list request, front first, with m_last_of_run set on the final one.
// Unused action codes are accepted and produce no result.
// The first result of an accepted request reaches the output register in the
// next cycle. Pushes, pops and clears run at one request per cycle while the
// receiver takes each result; a list request over N elements holds s_ready
// low and streams N results through the single read port on the cell row.
// A synchronous low aresetn empties the queue; cell contents are left as they
// are and are never read before being written.
// When the receiver stalls, the result is held in the output register and
// s_ready drops until it is taken; the same cycle that frees it may take a new
// request.
module double_ended_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_action,
    input  logic signed [dq_pkg::DATA_W-1:0] s_item_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [dq_pkg::DATA_W-1:0] m_result_value,
    output logic [1:0]                       m_status,
    output logic                             m_last_of_run
);

    localparam int DEPTH = dq_pkg::DEPTH;
    localparam int IDX_W = dq_pkg::IDX_W;
    localparam int CNT_W = dq_pkg::CNT_W;
    localparam int DW    = dq_pkg::DATA_W;

    // The front of the queue always sits in cell 0; the count gives the back.
    logic [CNT_W-1:0] count_reg, count_next;
    logic             list_active_reg, list_active_next;
    logic [IDX_W-1:0] list_idx_reg, list_idx_next;

    logic                  m_valid_reg, m_valid_next;
    logic signed [DW-1:0]  m_value_reg, m_value_next;
    dq_pkg::status_t       m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    dq_pkg::action_t   action;
    logic              accept;
    logic              out_free;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  rd_idx;
    logic signed [DW-1:0] rd_data;
    logic              do_shift_r;
    logic              do_shift_l;
    logic              do_push_back;

    logic signed [DW-1:0] cell_q [DEPTH];
    dq_pkg::cell_ctl_t    cell_ctl [DEPTH];

    assign action   = dq_pkg::action_t'(s_action);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !list_active_reg && out_free;
    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign cnt_m1   = count_reg - CNT_W'(1);

    // Single read port on the row: the list pointer while streaming, the back
    // element for a pop at the back, and the front cell otherwise.
    always_comb begin
        if (list_active_reg) begin
            rd_idx = list_idx_reg;
        end else if (action == dq_pkg::ACT_POP_BACK) begin
            rd_idx = cnt_m1[IDX_W-1:0];
        end else begin
            rd_idx = '0;
        end
    end

    assign rd_data = cell_q[rd_idx];

    // The cell row. Each cell talks to its neighbours only; the pushed value
    // enters at cell 0 from the left, or directly at the back cell.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DW-1:0] left_in;
        logic signed [DW-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = s_item_value;
        end else begin : g_mid_l
            assign left_in = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_q[i+1];
        end

        assign cell_ctl[i] = '{
            shift_r: do_shift_r,
            shift_l: do_shift_l,
            load:    do_push_back && (count_reg == CNT_W'(i))
        };

        dq_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[i]),
            .left_in  (left_in),
            .right_in (right_in),
            .ext_in   (s_item_value),
            .q        (cell_q[i])
        );
    end

    // Request decoding and result generation.
    always_comb begin
        count_next       = count_reg;
        list_active_next = list_active_reg;
        list_idx_next    = list_idx_reg;
        do_shift_r       = 1'b0;
        do_shift_l       = 1'b0;
        do_push_back     = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        if (list_active_reg) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_value_next  = rd_data;
                m_status_next = dq_pkg::ST_OK;
                m_last_next   = ((CNT_W'(list_idx_reg) + CNT_W'(1)) == count_reg);
                list_idx_next = list_idx_reg + IDX_W'(1);
                if (m_last_next) begin
                    list_active_next = 1'b0;
                end
            end
        end else if (accept) begin
            m_value_next  = '0;
            m_status_next = dq_pkg::ST_OK;
            m_last_next   = 1'b1;
            m_valid_next  = 1'b1;
            case (action)
                dq_pkg::ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        m_status_next = dq_pkg::ST_FULL;
                    end else begin
                        do_shift_r = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                dq_pkg::ACT_PUSH_BACK: begin
                    if (is_full) begin
                        m_status_next = dq_pkg::ST_FULL;
                    end else begin
                        do_push_back = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
                    if (is_empty) begin
                        m_status_next = dq_pkg::ST_EMPTY;
                    end else begin
                        m_value_next = rd_data;
                        do_shift_l   = (action == dq_pkg::ACT_POP_FRONT);
                        count_next   = cnt_m1;
                    end
                end
                dq_pkg::ACT_CLEAR: begin
                    count_next = '0;
                end
                dq_pkg::ACT_LIST: begin
                    if (is_empty) begin
                        m_status_next = dq_pkg::ST_EMPTY;
                    end else begin
                        // First element goes out now; the rest stream from cell 1.
                        m_value_next = rd_data;
                        m_last_next  = (count_reg == CNT_W'(1));
                        if (!m_last_next) begin
                            list_active_next = 1'b1;
                            list_idx_next    = IDX_W'(1);
                        end
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                    m_status_next = m_status_reg;
                    m_value_next  = m_value_reg;
                    m_last_next   = m_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            list_active_reg <= 1'b0;
            list_idx_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            count_reg       <= count_next;
            list_active_reg <= list_active_next;
            list_idx_reg    <= list_idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_last_of_run  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

    a_list_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        list_active_reg |-> !s_ready)
        else $error("request taken while a list is streaming");

    a_list_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        list_active_reg |=> (count_reg == $past(count_reg)))
        else $error("element count changed during a list");

    a_not_last_only_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> list_active_reg)
        else $error("non-final result outside a list");

    a_status_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != dq_pkg::ST_OK)) |-> (m_value_reg == '0))
        else $error("empty or full result carries a value");
`endif

endmodule
